/* design/dlm_pkg.sv */
// Shared constants and operation codes for the dense layer momentum SGD engine.
`default_nettype none
package dlm_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;

    localparam int OP_W   = 3;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int DATA_W = 32;
    localparam int GRAD_W = 48;
    localparam int RATE_W = 16;
    localparam int CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_INPUT  = 3'd1;
    localparam logic [OP_W-1:0] OP_GRADIENT    = 3'd2;
    localparam logic [OP_W-1:0] OP_APPLY       = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_WEIGHT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_OUTPUTS  = 2'd3;

endpackage
`default_nettype wire

/* design/dlm_if.sv */
// Handshake interfaces for the request, response and configuration channels.
`default_nettype none
interface dlm_req_if;
    import dlm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, op, row, col, value, input ready);
    modport sink (input valid, op, row, col, value, output ready);
endinterface

interface dlm_rsp_if;
    import dlm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic                     update_done;
    modport source (output valid, read_value, update_done, input ready);
    modport sink (input valid, read_value, update_done, output ready);
endinterface

interface dlm_cfg_if;
    import dlm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/dlm_ram.sv */
// Generic simple dual port RAM with one write port and a registered read port.
`default_nettype none
module dlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [$clog2(DEPTH)-1:0]       waddr,
    input  wire logic [WIDTH-1:0]               wdata,
    input  wire logic [$clog2(DEPTH)-1:0]       raddr,
    output logic      [WIDTH-1:0]               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/dense_layer_momentum_sgd_update.sv */
// Top level: one dense layer's weight store with gradient accumulation and momentum SGD.
// Each weight or bias element passes through read, multiply, sum and write back states.
// A gradient beat accumulates into one row's active input and bias gradients; an apply
// beat updates every active row, then sends a completion beat; loads write in the cycle
// they are taken, and a read returns the weight on a response beat. After reset a
// clearing pass zeroes all gradient and delta entries; no request is taken until it ends.
`default_nettype none
module dense_layer_momentum_sgd_update (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dlm_req_if.sink    req,
    dlm_rsp_if.source  rsp,
    dlm_cfg_if.sink    cfg
);
    import dlm_pkg::*;

    localparam int CW    = $clog2(MAX_INPUTS + 1);
    localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int AW    = OW + CW;
    localparam int DEPTH = MAX_OUTPUTS * (2 ** CW);
    localparam int RAW   = $clog2(DEPTH);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_RDA   = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [RATE_W-1:0]        lr_reg, mom_reg;
    logic [CNT_W-1:0]         ni_reg, no_reg;
    logic [RAW-1:0]           clr_reg, clr_next;
    logic [OW-1:0]            row_reg, row_next;
    logic [CW-1:0]            col_reg, col_next;
    logic                     apply_reg, apply_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] w_q_reg;
    logic signed [GRAD_W-1:0] g_q_reg;
    logic signed [64:0]       p1_reg;
    logic signed [48:0]       p2_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] delta_reg;
    logic signed [GRAD_W-1:0] gnew_reg;
    logic signed [DATA_W-1:0] pend_value_reg, pend_value_next;
    logic                     pend_done_reg, pend_done_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_done_reg;

    logic [CW-1:0]            last_col;
    logic [OW-1:0]            last_row;
    logic                     req_fire, in_range, is_bias;
    logic [AW-1:0]            req_addr, elem_addr;

    logic                     w_we, g_we, d_we, x_we;
    logic [RAW-1:0]           w_waddr, gd_waddr;
    logic [DATA_W-1:0]        w_wdata, d_wdata;
    logic [GRAD_W-1:0]        g_wdata;
    logic signed [DATA_W-1:0] w_rdata, d_rdata, x_rdata;
    logic signed [GRAD_W-1:0] g_rdata;

    logic signed [65:0]       dsum;
    logic signed [49:0]       dshift;
    logic signed [48:0]       gsum;
    logic signed [32:0]       wdiff;
    logic signed [DATA_W-1:0] delta_c, wnew_c;
    logic signed [GRAD_W-1:0] gnew_c;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.update_done = out_done_reg;

    assign in_range  = (int'(req.row) < MAX_OUTPUTS) && (int'(req.col) <= MAX_INPUTS);
    assign req_addr  = {OW'(req.row), CW'(req.col)};
    assign elem_addr = {row_reg, col_reg};
    assign is_bias   = (int'(col_reg) == MAX_INPUTS);

    always_comb
    begin
        if (ni_reg == '0)
        begin
            last_col = '0;
        end
        else if (int'(ni_reg) > MAX_INPUTS)
        begin
            last_col = CW'(MAX_INPUTS - 1);
        end
        else
        begin
            last_col = CW'(ni_reg - 7'd1);
        end
        if (no_reg == '0)
        begin
            last_row = '0;
        end
        else if (int'(no_reg) > MAX_OUTPUTS)
        begin
            last_row = OW'(MAX_OUTPUTS - 1);
        end
        else
        begin
            last_row = OW'(no_reg - 7'd1);
        end
    end

    always_comb
    begin
        dsum   = 66'(p1_reg) + 66'(p2_reg);
        dshift = 50'(dsum >>> 16);
        if (dshift > 50'sd2147483647)
        begin
            delta_c = 32'sh7fffffff;
        end
        else if (dshift < -50'sd2147483648)
        begin
            delta_c = 32'sh80000000;
        end
        else
        begin
            delta_c = dshift[31:0];
        end
        gsum = 49'(g_q_reg) + 49'(prod_reg >>> 16);
        if (gsum[48] != gsum[47])
        begin
            gnew_c = gsum[48] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
        end
        else
        begin
            gnew_c = gsum[47:0];
        end
        wdiff = 33'(w_q_reg) - 33'(delta_reg);
        if (wdiff[32] != wdiff[31])
        begin
            wnew_c = wdiff[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            wnew_c = wdiff[31:0];
        end
    end

    always_comb
    begin
        w_we     = 1'b0;
        w_waddr  = RAW'(elem_addr);
        w_wdata  = wnew_c;
        g_we     = 1'b0;
        g_wdata  = apply_reg ? '0 : gnew_reg;
        d_we     = 1'b0;
        d_wdata  = delta_reg;
        gd_waddr = RAW'(elem_addr);
        x_we     = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            g_we     = 1'b1;
            d_we     = 1'b1;
            g_wdata  = '0;
            d_wdata  = '0;
            gd_waddr = clr_reg;
        end
        else if (state_reg == S_IDLE)
        begin
            w_waddr = RAW'(req_addr);
            w_wdata = req.value;
            w_we    = req_fire && (req.op == OP_LOAD_WEIGHT) && in_range;
            x_we    = req_fire && (req.op == OP_LOAD_INPUT) && (int'(req.col) < MAX_INPUTS);
        end
        else if (state_reg == S_WB)
        begin
            g_we = 1'b1;
            w_we = apply_reg;
            d_we = apply_reg;
        end
    end

    dlm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_weight_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(RAW'(elem_addr)), .rdata(w_rdata)
    );

    dlm_ram #(.WIDTH(GRAD_W), .DEPTH(DEPTH)) u_grad_ram (
        .clk(clk), .we(g_we), .waddr(gd_waddr), .wdata(g_wdata),
        .raddr(RAW'(elem_addr)), .rdata(g_rdata)
    );

    dlm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_delta_ram (
        .clk(clk), .we(d_we), .waddr(gd_waddr), .wdata(d_wdata),
        .raddr(RAW'(elem_addr)), .rdata(d_rdata)
    );

    dlm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INPUTS)) u_input_ram (
        .clk(clk), .we(x_we), .waddr(req.col[IW-1:0]), .wdata(req.value),
        .raddr(col_reg[IW-1:0]), .rdata(x_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        apply_next      = apply_reg;
        rd_ok_next      = rd_ok_reg;
        value_next      = value_reg;
        pend_value_next = pend_value_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    value_next = req.value;
                    if (req.op == OP_GRADIENT && int'(req.row) <= int'(last_row))
                    begin
                        row_next   = OW'(req.row);
                        col_next   = '0;
                        apply_next = 1'b0;
                        state_next = S_RD;
                    end
                    else if (req.op == OP_APPLY)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        apply_next = 1'b1;
                        state_next = S_RD;
                    end
                    else if (req.op == OP_READ_WEIGHT)
                    begin
                        row_next   = OW'(req.row);
                        col_next   = CW'(req.col);
                        rd_ok_next = in_range;
                        state_next = S_RDA;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_RD;
                if (is_bias)
                begin
                    if (apply_reg && row_reg != last_row)
                    begin
                        row_next = row_reg + 1'b1;
                        col_next = '0;
                    end
                    else if (apply_reg)
                    begin
                        pend_value_next = '0;
                        pend_done_next  = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (col_reg == last_col)
                begin
                    col_next = CW'(MAX_INPUTS);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_RDA:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                pend_value_next = rd_ok_reg ? w_rdata : '0;
                pend_done_next  = 1'b0;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            apply_reg     <= 1'b0;
            rd_ok_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            lr_reg        <= '0;
            mom_reg       <= '0;
            ni_reg        <= CNT_W'(MAX_INPUTS);
            no_reg        <= CNT_W'(MAX_OUTPUTS);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            apply_reg     <= apply_next;
            rd_ok_reg     <= rd_ok_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LEARNING_RATE:   lr_reg  <= cfg.data;
                    REG_MOMENTUM_FACTOR: mom_reg <= cfg.data;
                    REG_ACTIVE_INPUTS:   ni_reg  <= cfg.data[CNT_W-1:0];
                    REG_ACTIVE_OUTPUTS:  no_reg  <= cfg.data[CNT_W-1:0];
                    default:             lr_reg  <= lr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        pend_value_reg <= pend_value_next;
        pend_done_reg  <= pend_done_next;
        if (state_reg == S_OUT && (!out_valid_reg || rsp.ready))
        begin
            out_value_reg <= pend_value_reg;
            out_done_reg  <= pend_done_reg;
        end
        if (state_reg == S_MUL)
        begin
            w_q_reg <= w_rdata;
            g_q_reg <= g_rdata;
            p1_reg  <= $signed({1'b0, lr_reg}) * g_rdata;
            p2_reg  <= $signed({1'b0, mom_reg}) * d_rdata;
            if (is_bias)
            begin
                prod_reg <= {{16{value_reg[31]}}, value_reg, 16'h0000};
            end
            else
            begin
                prod_reg <= value_reg * x_rdata;
            end
        end
        if (state_reg == S_ADD)
        begin
            delta_reg <= delta_c;
            gnew_reg  <= gnew_c;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.update_done |-> rsp.read_value == '0)
        else $error("completion beat carries nonzero read value");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB && !apply_reg |-> !w_we && !d_we)
        else $error("gradient pass wrote weights or deltas");
`endif

endmodule
`default_nettype wire
